// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- sv/fbfla_pkg.sv -----
// ----------------------------------------------------------------------------
// fbfla_pkg
// Widths, codes and helpers of the fixed block free list allocator.
// ----------------------------------------------------------------------------
package fbfla_pkg;

  localparam int unsigned MaxBlocksDef = 256;
  localparam int unsigned PoolLimit    = 256;  // hard cap on pool size
  localparam int unsigned AlignLog2    = 3;    // 8 byte alignment

  localparam int unsigned BlockSizeW = 17;
  localparam int unsigned CountW     = 9;
  localparam int unsigned IndexW     = 8;
  localparam int unsigned OffsetW    = 24;
  localparam int unsigned ErrW       = 2;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 17;
  localparam int unsigned AsizeW     = BlockSizeW + 1;

  localparam logic [BlockSizeW-1:0] BlockSizeRst = BlockSizeW'(64);

  // opcodes
  localparam logic OpAlloc   = 1'b0;
  localparam logic OpRelease = 1'b1;

  // error codes
  localparam logic [ErrW-1:0] ErrNone  = 2'd0;
  localparam logic [ErrW-1:0] ErrEmpty = 2'd1;
  localparam logic [ErrW-1:0] ErrFull  = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgBlockSize  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBlockCount = 1'b1;

  // link memory access
  typedef struct packed {
    logic              we;
    logic [IndexW-1:0] waddr;
    logic [IndexW-1:0] wdata;
    logic              re;
    logic [IndexW-1:0] raddr;
  } link_req_t;

  // round a byte size up to the alignment
  function automatic logic [AsizeW-1:0] align_size(input logic [BlockSizeW-1:0] s);
    logic [AsizeW-1:0] mask;
    logic [AsizeW-1:0] sum;
    mask = AsizeW'((1 << AlignLog2) - 1);
    sum  = AsizeW'(s) + mask;
    return sum & ~mask;
  endfunction

endpackage

// ----- sv/fbfla_link_mem.sv -----
// ----------------------------------------------------------------------------
// fbfla_link_mem
// Free list link store: one write port, one registered read port, valid bits
// so that an entry never written reads as its own index plus one.
// ----------------------------------------------------------------------------
module fbfla_link_mem #(
  parameter int unsigned Depth = fbfla_pkg::MaxBlocksDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clr_i,
  input  fbfla_pkg::link_req_t      req_i,
  output logic [fbfla_pkg::IndexW-1:0] rdata_o
);
  import fbfla_pkg::*;

  localparam int unsigned AW = $clog2(Depth);

  logic [AW-1:0]    mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [AW-1:0]    rd_q;
  logic [AW-1:0]    rdef_q;
  logic             rvld_q;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;

  assign waddr = req_i.waddr[AW-1:0];
  assign raddr = req_i.raddr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[waddr] <= req_i.wdata[AW-1:0];
    end
    if (req_i.re) begin
      rd_q   <= mem[raddr];
      rvld_q <= vld_q[raddr];
      rdef_q <= raddr + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (req_i.we) begin
      vld_q[waddr] <= 1'b1;
    end
  end

  // unwritten entries hold the initial chain value
  assign rdata_o = IndexW'(rvld_q ? rd_q : rdef_q);

endmodule

// ----- sv/fixed_block_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// LIFO free list allocator over a pool of equal size blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (opcode_i, block_index_i) is taken on a clock
//   edge with start_i high and busy_o low. busy_o stays low, so a new item
//   can be issued every cycle.
//   Result: in the cycle after the item is taken, done_o pulses for one cycle
//   with ok_o, granted_index_o, granted_offset_o, free_count_o, error_o.
//   Throughput 1 item per cycle. The next free block is
//   prefetched from the link memory (its read port is registered); a pop that
//   follows a pop uses that read data directly, a push supplies the old
//   head as the next entry without a read.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i, cfg_data_i.
//   Index 0 is the block size register, index 1 is block_count; writing
//   block_count rebuilds the pool (chain 0,1,2..., head 0, all blocks free).
//   cfg_ready_o is low while start_i is high, so a write never shares an
//   edge with an item. Write it only while no result is outstanding.
//   Reset: block size 64, pool of min(256, MAX_BLOCKS) free blocks.
//   The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator #(
  parameter int unsigned MAX_BLOCKS = fbfla_pkg::MaxBlocksDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command channel
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            opcode_i,
  input  logic [fbfla_pkg::IndexW-1:0]    block_index_i,
  // result channel
  output logic                            done_o,
  output logic                            ok_o,
  output logic [fbfla_pkg::IndexW-1:0]    granted_index_o,
  output logic [fbfla_pkg::OffsetW-1:0]   granted_offset_o,
  output logic [fbfla_pkg::CountW-1:0]    free_count_o,
  output logic [fbfla_pkg::ErrW-1:0]      error_o,
  // config channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fbfla_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fbfla_pkg::CfgDataW-1:0]  cfg_data_i
);
  import fbfla_pkg::*;

  // effective pool depth
  localparam int unsigned Depth = (MAX_BLOCKS < PoolLimit) ? MAX_BLOCKS : PoolLimit;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned ProdW = IdxW + AsizeW;
  localparam logic [CountW-1:0] PoolMax = CountW'(Depth);

  logic [AsizeW-1:0] asize_q;    // aligned block size
  logic [CountW-1:0] pool_q;     // pool size in use
  logic [CountW-1:0] free_q, free_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic [IdxW-1:0]   next_q, next_d;
  logic              pend_q, pend_d;  // next head arrives from link memory
  logic [IdxW-1:0]   next_cur;

  logic              done_q;
  logic              ok_q, ok_d;
  logic [IndexW-1:0] gidx_q, gidx_d;
  logic [OffsetW-1:0] goff_q, goff_d;
  logic [CountW-1:0] fcnt_q;
  logic [ErrW-1:0]   err_q, err_d;

  logic              accept;
  logic              cfg_we;
  logic              rebuild;
  logic [CountW-1:0] pool_new;
  logic [ProdW-1:0]  prod;
  link_req_t         link_req;
  logic [IndexW-1:0] link_rdata;

  assign busy_o      = 1'b0;
  // config waits for a cycle without an item
  assign cfg_ready_o = ~start_i;
  assign accept      = start_i & ~busy_o;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign rebuild     = cfg_we && (cfg_index_i == CfgBlockCount);

  // clamp requested count to the pool depth
  assign pool_new = (cfg_data_i[CountW-1:0] > PoolMax) ? PoolMax : cfg_data_i[CountW-1:0];

  // offset of the block at the head
  assign prod = ProdW'(head_q) * ProdW'(asize_q);

  fbfla_link_mem #(
    .Depth (Depth)
  ) u_link_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (rebuild),
    .req_i   (link_req),
    .rdata_o (link_rdata)
  );

  always_comb begin
    next_cur = pend_q ? link_rdata[IdxW-1:0] : next_q;
    head_d   = head_q;
    next_d   = next_cur;
    pend_d   = 1'b0;
    free_d   = free_q;
    ok_d     = 1'b0;
    err_d    = ErrNone;
    gidx_d   = '0;
    goff_d   = '0;
    link_req = '0;

    if (rebuild) begin
      head_d = '0;
      next_d = IdxW'(1);
      free_d = pool_new;
    end else if (accept) begin
      if (opcode_i == OpAlloc) begin
        if (free_q == '0) begin
          err_d = ErrEmpty;
        end else begin
          // pop head, fetch the link of the new head
          ok_d           = 1'b1;
          gidx_d         = IndexW'(head_q);
          goff_d         = OffsetW'(prod);
          head_d         = next_cur;
          link_req.re    = 1'b1;
          link_req.raddr = IndexW'(next_cur);
          pend_d         = 1'b1;
          free_d         = free_q - CountW'(1);
        end
      end else begin
        if ((free_q >= pool_q) || (CountW'(block_index_i) >= pool_q)) begin
          err_d = ErrFull;
        end else begin
          // push: link the old head behind the released block
          ok_d           = 1'b1;
          link_req.we    = 1'b1;
          link_req.waddr = block_index_i;
          link_req.wdata = IndexW'(head_q);
          head_d         = block_index_i[IdxW-1:0];
          next_d         = head_q;
          free_d         = free_q + CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asize_q <= align_size(BlockSizeRst);
      pool_q  <= PoolMax;
      free_q  <= PoolMax;
      head_q  <= '0;
      next_q  <= IdxW'(1);
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index_i == CfgBlockSize)) begin
        asize_q <= align_size(cfg_data_i[BlockSizeW-1:0]);
      end
      if (rebuild) begin
        pool_q <= pool_new;
      end
      free_q <= free_d;
      head_q <= head_d;
      next_q <= next_d;
      pend_q <= pend_d;
      done_q <= accept & ~rebuild;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    ok_q   <= ok_d;
    gidx_q <= gidx_d;
    goff_q <= goff_d;
    fcnt_q <= free_d;
    err_q  <= err_d;
  end

  assign done_o           = done_q;
  assign ok_o             = ok_q;
  assign granted_index_o  = gidx_q;
  assign granted_offset_o = goff_q;
  assign free_count_o     = fcnt_q;
  assign error_o          = err_q;

endmodule

// ----- sv/fbfla_checker.sv -----
// ----------------------------------------------------------------------------
// fbfla_port_checker
// Port level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbfla_port_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic                            opcode_i,
  input logic                            done_o,
  input logic                            ok_o,
  input logic [fbfla_pkg::IndexW-1:0]    granted_index_o,
  input logic [fbfla_pkg::OffsetW-1:0]   granted_offset_o,
  input logic [fbfla_pkg::CountW-1:0]    free_count_o,
  input logic [fbfla_pkg::ErrW-1:0]      error_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o
);
  import fbfla_pkg::*;

  logic cmd_acc;
  logic cfg_acc;
  logic rel_acc;
  logic ok_err_bad;
  logic grant_zero;
  logic empty_seen;

  assign cmd_acc    = start_i && !busy_o;
  assign cfg_acc    = cfg_valid_i && cfg_ready_o;
  assign rel_acc    = cmd_acc && (opcode_i == OpRelease);
  assign ok_err_bad = done_o && (ok_o == (error_o != ErrNone));
  assign grant_zero = (granted_index_o == '0) && (granted_offset_o == '0);
  assign empty_seen = done_o && (error_o == ErrEmpty);

  // one result for each item, in the cycle after it is taken
  `ASSERT_PROP(a_done_follows_start, clk_i, rst_ni, cmd_acc |=> done_o, "item without result")

  // a config write never shares an edge with an item
  `ASSERT_NEVER(a_cfg_no_item, clk_i, rst_ni, cmd_acc && cfg_acc, "config write with item")

  // ok and error code exclude each other
  `ASSERT_NEVER(a_ok_err_excl, clk_i, rst_ni, ok_err_bad, "ok and error disagree")

  // a release grants no block
  `ASSERT_PROP(a_grant_zero, clk_i, rst_ni, rel_acc |=> grant_zero, "release shows a grant")

  // allocate on empty pool reports zero free
  `ASSERT_PROP(a_empty_count, clk_i, rst_ni, empty_seen |-> free_count_o == '0, "empty error")

endmodule

bind fixed_block_free_list_allocator fbfla_port_checker u_fbfla_checker (.*);
